// ===== design/bidirectional_flow_table_with_timeout_core_assert.svh =====
// Assertion macros for the flow table core.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef BIDIRECTIONAL_FLOW_TABLE_WITH_TIMEOUT_CORE_ASSERT_SVH
`define BIDIRECTIONAL_FLOW_TABLE_WITH_TIMEOUT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bft_pkg.sv =====
// Shared types and constants for the flow table core.
// No dependencies; imported by bft_out_if and all modules.
package bft_pkg;

    localparam int FLOW_SLOTS = 32;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int OUT_SLOT_W = 5;
    localparam int MASK_W     = 32;

    localparam logic [15:0] TIMEOUT_RESET = 16'd60;

    localparam logic [1:0] STATUS_MATCH = 2'd0;
    localparam logic [1:0] STATUS_NEW   = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_tuple;

    // Verdict of the slot compare unit for one slot
    typedef struct packed {
        logic match;
        logic expired;
    } t_cmp_res;

endpackage

// ===== design/bft_if.sv =====
// Valid/ready channel interfaces for packet items and lookup results.
// Depends on bft_pkg for field widths.
interface bft_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] now_seconds;

    modport source (output valid, src_addr, dst_addr, src_port, dst_port, now_seconds,
                    input ready);
    modport sink   (input valid, src_addr, dst_addr, src_port, dst_port, now_seconds,
                    output ready);
endinterface

interface bft_out_if import bft_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [MASK_W-1:0]     cleared_mask;

    modport source (output valid, status, slot, cleared_mask, input ready);
    modport sink   (input valid, status, slot, cleared_mask, output ready);
endinterface

// ===== design/bft_slot_cmp.sv =====
// Shared slot compare unit: tuple match in both directions and idle age test.
// Depends on bft_pkg for the tuple and verdict types.
module bft_slot_cmp import bft_pkg::*; (
    input  logic        i_occupied,
    input  t_tuple      i_slot_tuple,
    input  logic [31:0] i_slot_last_seen,
    input  t_tuple      i_pkt_tuple,
    input  logic [31:0] i_now,
    input  logic [15:0] i_timeout,
    output t_cmp_res    o_res
);

    logic        same_dir;
    logic        swap_dir;
    logic [31:0] age;

    // Compare as is and with source and destination swapped
    assign same_dir = (i_slot_tuple == i_pkt_tuple);
    assign swap_dir = (i_slot_tuple.src_addr == i_pkt_tuple.dst_addr) &&
                      (i_slot_tuple.dst_addr == i_pkt_tuple.src_addr) &&
                      (i_slot_tuple.src_port == i_pkt_tuple.dst_port) &&
                      (i_slot_tuple.dst_port == i_pkt_tuple.src_port);

    // Age wraps modulo 2^32
    assign age = i_now - i_slot_last_seen;

    // Matching wins over aging; empty slots never match
    assign o_res.match   = i_occupied && (same_dir || swap_dir);
    assign o_res.expired = i_occupied && !(same_dir || swap_dir) &&
                           (age > {16'd0, i_timeout});

endmodule

// ===== design/bidirectional_flow_table_with_timeout_core.sv =====
// Flow table core: sequencer, slot memories, occupancy bits and result register.
// Depends on bft_pkg, bft_if.sv, bft_slot_cmp and the assertion macro header.
//
// Usage:
//   i_in carries one packet item: four-tuple plus the current second. o_out
//   returns one result item per packet: status, slot index and the mask of
//   slots freed for idle timeout during that lookup.
//   i_cfg_we/i_cfg_wdata write the 16-bit idle timeout; write only while idle.
// Sequence:
//   An item is accepted, then the slots are scanned in order (up to
//   FLOW_SLOTS, fewer when a match stops the scan), then the result is
//   loaded into the result register once that is free. The single compare
//   unit walks the slot memory one read per cycle.
//   The input is ready only between items.
// Reset:
//   All slots become free and the timeout returns to 60 seconds. Slot
//   contents are not cleared; the occupancy bits alone decide matching.
//   The input is not ready while reset is asserted.
// Stall:
//   The result register holds its item until taken. A following packet may
//   be scanned meanwhile; its result waits in the finish step until the
//   register is free.
`include "bidirectional_flow_table_with_timeout_core_assert.svh"

module bidirectional_flow_table_with_timeout_core import bft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    bft_in_if.sink      i_in,
    bft_out_if.source   o_out
);

    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_idx;
    logic [FLOW_SLOTS-1:0] r_occ;
    logic [15:0]           r_timeout;
    t_tuple                r_pkt;
    logic [31:0]           r_now;
    logic [MASK_W-1:0]     r_mask;
    logic                  r_have_free;
    logic [SLOT_W-1:0]     r_free_idx;

    logic [1:0]            r_res_status;
    logic [OUT_SLOT_W-1:0] r_res_slot;
    logic [MASK_W-1:0]     r_res_mask;

    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [OUT_SLOT_W-1:0] r_out_slot;
    logic [MASK_W-1:0]     r_out_mask;

    t_tuple                r_tuple_mem [FLOW_SLOTS];
    logic [31:0]           r_time_mem  [FLOW_SLOTS];
    t_tuple                r_rd_tuple;
    logic [31:0]           r_rd_time;

    logic                  in_ready;
    logic                  scan_en;
    logic                  load_out;
    logic                  out_free;
    logic                  accept;
    logic                  last;
    logic                  done;
    logic                  free_here;
    logic                  alloc;
    logic [SLOT_W-1:0]     alloc_idx;
    logic [SLOT_W-1:0]     rd_addr;
    logic [MASK_W-1:0]     scan_mask;
    t_cmp_res              cmp;
    t_tuple                in_tuple;

    assign out_free = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && in_ready;
    assign last     = (r_idx == SLOT_W'(FLOW_SLOTS - 1));
    assign in_tuple = '{src_addr: i_in.src_addr, dst_addr: i_in.dst_addr,
                        src_port: i_in.src_port, dst_port: i_in.dst_port};

    // Compare the slot under evaluation against the packet
    bft_slot_cmp u_cmp (
        .i_occupied      (r_occ[r_idx]),
        .i_slot_tuple    (r_rd_tuple),
        .i_slot_last_seen(r_rd_time),
        .i_pkt_tuple     (r_pkt),
        .i_now           (r_now),
        .i_timeout       (r_timeout),
        .o_res           (cmp)
    );

    // Scan bookkeeping for the current slot
    assign free_here = !r_occ[r_idx] || cmp.expired;
    assign done      = cmp.match || last;
    assign alloc     = !cmp.match && last && (r_have_free || free_here);
    assign alloc_idx = r_have_free ? r_free_idx : r_idx;
    assign scan_mask = cmp.expired ? (r_mask | (MASK_W'(1) << r_idx)) : r_mask;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = ST_SCAN;
            ST_SCAN:   if (done) n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        scan_en  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:   in_ready = i_rst_n;
            ST_SCAN:   scan_en  = 1'b1;
            ST_FINISH: load_out = out_free;
            default:   in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // Occupancy bits: drop expired slots, mark the allocated one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (scan_en) begin
            if (cmp.expired) r_occ[r_idx] <= 1'b0;
            if (alloc) r_occ[alloc_idx] <= 1'b1;
        end
    end

    // Latch the packet and walk the slot index
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pkt       <= in_tuple;
            r_now       <= i_in.now_seconds;
            r_idx       <= '0;
            r_mask      <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
        end else if (scan_en) begin
            r_idx  <= r_idx + SLOT_W'(1);
            r_mask <= scan_mask;
            if (free_here && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_idx;
            end
        end
    end

    // Capture the verdict when the scan ends
    always_ff @(posedge i_clk) begin
        if (scan_en && done) begin
            r_res_mask <= scan_mask;
            if (cmp.match) begin
                r_res_status <= STATUS_MATCH;
                r_res_slot   <= OUT_SLOT_W'(r_idx);
            end else if (alloc) begin
                r_res_status <= STATUS_NEW;
                r_res_slot   <= OUT_SLOT_W'(alloc_idx);
            end else begin
                r_res_status <= STATUS_FULL;
                r_res_slot   <= '0;
            end
        end
    end

    // Slot memories: read one slot ahead, write at the end of the scan
    assign rd_addr = (r_state == ST_IDLE || last) ? '0 : r_idx + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (scan_en && alloc) begin
            r_tuple_mem[alloc_idx] <= r_pkt;
        end
        r_rd_tuple <= r_tuple_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (scan_en && (alloc || cmp.match)) begin
            r_time_mem[cmp.match ? r_idx : alloc_idx] <= r_now;
        end
        r_rd_time <= r_time_mem[rd_addr];
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_mask   <= r_res_mask;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.slot         = r_out_slot;
    assign o_out.cleared_mask = r_out_mask;

    `BFT_ASSERT_NEXT(a_accept_starts_scan, accept,
        (r_state == ST_SCAN) && (r_idx == '0), "accepted item did not start a scan at slot 0")
    `BFT_ASSERT_NEXT(a_finish_loads_out, load_out, r_out_valid,
        "finished lookup did not load the result register")
    `BFT_ASSERT_NOW(a_full_slot_zero, r_out_valid && (r_out_status == STATUS_FULL),
        r_out_slot == '0, "table-full result with nonzero slot")
    `BFT_ASSERT_NEXT(a_occ_only_in_scan, r_state != ST_SCAN, $stable(r_occ),
        "occupancy changed outside a scan")

endmodule
